/* design/skf_pkg.sv */
// ----------------------------------------------------------------------------
// skf_pkg: shared types and constants of the scalar Kalman smoother
// Holds the sequencer states, the register index codes and the fixed-point
// widths used by the interfaces and the datapath.
// ----------------------------------------------------------------------------
package skf_pkg;

  // Field widths of the words on the channels.
  localparam int SAMPLE_W   = 16;
  localparam int ESTIMATE_W = 32;
  localparam int GAIN_W     = 17;
  localparam int COV_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  // Fixed-point constants, Q16.16 and Q1.16.
  localparam int FRAC_W = 16;
  localparam logic [COV_W-1:0]  RESET_R   = 32'd655;
  localparam logic [COV_W-1:0]  ONE_COV   = 32'd65536;
  localparam logic [GAIN_W-1:0] ONE_GAIN  = 17'd65536;

  // Number of serial steps for the divider and the multipliers.
  localparam int STEPS   = GAIN_W;
  localparam int CNT_W   = 5;

  // Register index codes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROCESS_NOISE     = 2'd0,
    CFG_MEASUREMENT_NOISE = 2'd1
  } cfg_idx_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRED,
    ST_DEN,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_t;

endpackage

/* design/skf_in_if.sv */
// ----------------------------------------------------------------------------
// skf_in_if: sample channel of the scalar Kalman smoother
// Valid/ready channel that carries one signed 16-bit sample per word.
// ----------------------------------------------------------------------------
interface skf_in_if;
  import skf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

/* design/skf_out_if.sv */
// ----------------------------------------------------------------------------
// skf_out_if: result channel of the scalar Kalman smoother
// Valid/ready channel that carries the new estimate and the gain per word.
// ----------------------------------------------------------------------------
interface skf_out_if;
  import skf_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [ESTIMATE_W-1:0] estimate;
  logic        [GAIN_W-1:0]     gain;

  modport source (output valid, output estimate, output gain, input ready);
  modport sink   (input valid, input estimate, input gain, output ready);

endinterface

/* design/scalar_kalman_smoother.sv */
// ----------------------------------------------------------------------------
// scalar_kalman_smoother: one-dimensional Kalman filter, bit-serial datapath
// Constant-state model: predict P + Q (saturating), gain P/(P+R) by a
// restoring divider one quotient bit per cycle, then estimate and covariance
// updates by two shift-add multipliers one gain bit per cycle.
//
//   channel   direction   contents                          handshake
//   in_ch     in          sample  s16                       valid/ready
//   out_ch    out         estimate s32 Q16.16, gain u17     valid/ready
//   cfg_*     in          index 2 bits, data 32 bits        write enable
//
// A word passes from acceptance to the result register through one
// prediction state, one denominator state, 17 divider steps, 17 multiplier
// steps and one write-back state.
// Reset (synchronous, rst_n low) loads Q = 0, R = 655, P = 1.0, x = 0.
// A new sample is taken only in the idle state; a held result does not stop
// that, but the write-back waits while the result register is full and the sink is not ready.
// ----------------------------------------------------------------------------
module scalar_kalman_smoother (
  input  logic                          clk,
  input  logic                          rst_n,
  skf_in_if.sink                        in_ch,
  skf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [skf_pkg::CFG_W-1:0]     cfg_data
);
  import skf_pkg::*;

  localparam int E_W    = ESTIMATE_W + 2;        // innovation, 34 bits signed
  localparam int DEN_W  = COV_W + 1;             // P + R, 33 bits
  localparam int REM_W  = COV_W + 2;             // divider remainder
  localparam int ACCE_W = E_W + GAIN_W;          // gain * innovation
  localparam int ACCP_W = COV_W + GAIN_W;        // (1 - gain) * P
  localparam int DLT_W  = ACCE_W - FRAC_W;       // floor(product / 2^16)
  localparam int XN_W   = ESTIMATE_W + 4;

  state_t state_r, state_nxt;

  logic [COV_W-1:0]             q_r, r_r;
  logic [COV_W-1:0]             p_r;
  logic signed [ESTIMATE_W-1:0] x_r;
  logic signed [SAMPLE_W-1:0]   sample_r;
  logic [COV_W-1:0]             pp_r;
  logic [DEN_W-1:0]             den_r;
  logic [REM_W-1:0]             rem_r;
  logic [GAIN_W-1:0]            gain_r;
  logic signed [E_W-1:0]        e_r;
  logic [GAIN_W-1:0]            ma_r, mp_r;
  logic [ACCE_W-1:0]            acc_e_r;
  logic [ACCP_W-1:0]            acc_p_r;
  logic [CNT_W-1:0]             cnt_r;
  logic                         out_valid_r;
  logic signed [ESTIMATE_W-1:0] out_est_r;
  logic [GAIN_W-1:0]            out_gain_r;

  // Combinational datapath terms.
  logic [COV_W:0]               pq_sum;
  logic [REM_W-1:0]             div_cand;
  logic                         div_bit;
  logic [E_W:0]                 sum_e;
  logic [COV_W:0]               sum_p;
  logic signed [DLT_W-1:0]      delta;
  logic signed [XN_W-1:0]       x_new;
  logic signed [ESTIMATE_W-1:0] x_sat;
  logic                         last_step;
  logic                         fin_go;

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
      r_r <= RESET_R;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROCESS_NOISE:     q_r <= cfg_data;
        CFG_MEASUREMENT_NOISE: r_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Predicted covariance and restoring division step.
  assign pq_sum    = {1'b0, p_r} + {1'b0, q_r};
  assign div_cand  = (cnt_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign div_bit   = (div_cand >= {1'b0, den_r});
  assign last_step = (cnt_r == CNT_W'(STEPS - 1));

  // Shift-add steps: signed gain * innovation, unsigned (1 - gain) * P.
  assign sum_e = {acc_e_r[ACCE_W-1], acc_e_r[ACCE_W-1:GAIN_W]}
               + (ma_r[0] ? {e_r[E_W-1], e_r} : '0);
  assign sum_p = {1'b0, acc_p_r[ACCP_W-1:GAIN_W]} + (mp_r[0] ? {1'b0, pp_r} : '0);

  // Estimate update with a clamp to the signed 32-bit range.
  assign delta = acc_e_r[ACCE_W-1:FRAC_W];
  assign x_new = XN_W'(x_r) + XN_W'(delta);
  always_comb begin
    if (x_new[XN_W-1:ESTIMATE_W-1] == '0 || x_new[XN_W-1:ESTIMATE_W-1] == '1) begin
      x_sat = x_new[ESTIMATE_W-1:0];
    end else if (x_new[XN_W-1]) begin
      x_sat = {1'b1, {(ESTIMATE_W-1){1'b0}}};
    end else begin
      x_sat = {1'b0, {(ESTIMATE_W-1){1'b1}}};
    end
  end

  assign fin_go = !out_valid_r || out_ch.ready;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_ch.valid) state_nxt = ST_PRED;
      ST_PRED: state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_DIV;
      ST_DIV:  if (last_step) state_nxt = ST_MUL;
      ST_MUL:  if (last_step) state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  // Filter state; reset loads P = 1.0 and x = 0.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= ONE_COV;
      x_r <= '0;
    end else if (state_r == ST_FIN && fin_go) begin
      p_r <= acc_p_r[COV_W+FRAC_W-1:FRAC_W];
      x_r <= x_sat;
    end
  end

  // Step counter for the divider and the multipliers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if ((state_r == ST_DIV || state_r == ST_MUL) && !last_step) begin
      cnt_r <= cnt_r + 1'b1;
    end else begin
      cnt_r <= '0;
    end
  end

  // Working registers of one word.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        sample_r <= in_ch.sample;
      end
      ST_PRED: begin
        pp_r <= pq_sum[COV_W] ? '1 : pq_sum[COV_W-1:0];
        e_r  <= {{2{sample_r[SAMPLE_W-1]}}, sample_r, {FRAC_W{1'b0}}}
              - {{2{x_r[ESTIMATE_W-1]}}, x_r};
      end
      ST_DEN: begin
        den_r  <= {1'b0, pp_r} + {1'b0, r_r};
        rem_r  <= {2'b00, pp_r};
        gain_r <= '0;
      end
      ST_DIV: begin
        rem_r  <= div_bit ? (div_cand - {1'b0, den_r}) : div_cand;
        gain_r <= {gain_r[GAIN_W-2:0], div_bit};
        if (last_step) begin
          // A zero denominator gives a zero gain.
          if (den_r == '0) begin
            ma_r <= '0;
            mp_r <= ONE_GAIN;
          end else begin
            ma_r <= {gain_r[GAIN_W-2:0], div_bit};
            mp_r <= ONE_GAIN - {gain_r[GAIN_W-2:0], div_bit};
          end
          acc_e_r <= '0;
          acc_p_r <= '0;
        end
      end
      ST_MUL: begin
        acc_e_r <= {sum_e, acc_e_r[GAIN_W-1:1]};
        acc_p_r <= {sum_p, acc_p_r[GAIN_W-1:1]};
        ma_r    <= {1'b0, ma_r[GAIN_W-1:1]};
        mp_r    <= {1'b0, mp_r[GAIN_W-1:1]};
        if (cnt_r == '0) begin
          gain_r <= ONE_GAIN - mp_r;
        end
      end
      default: ;
    endcase
  end

  // Result register; it holds a result for a stalled sink while the sequencer goes on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && fin_go) begin
      out_est_r  <= x_sat;
      out_gain_r <= gain_r;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.estimate = out_est_r;
  assign out_ch.gain     = out_gain_r;

endmodule
